[rtl/sfpe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sfpe_pkg;

  localparam int LEVEL_W = 7;
  localparam int TIME_W = 11;
  localparam logic [11:0] DAY_MINUTES = 12'd1440;
  localparam logic [10:0] LAST_MINUTE = 11'd1439;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_LEVEL  = 3'd2,
    CMD_LIMITS = 3'd3,
    CMD_EVAL   = 3'd4
  } cmd_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NO_SLOT = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  slot;
    logic [4:0]  at_hour;
    logic [5:0]  at_minute;
    logic        fade_on;
    logic [1:0]  channel;
    logic [6:0]  level;
    logic [11:0] limit_low;
    logic [11:0] limit_high;
    logic [10:0] now_minute;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  out_channel;
    logic [11:0] pwm;
    logic [1:0]  status;
    logic        last;
  } out_beat_t;

  // Division by 100 through a reciprocal; exact for inputs below 2**20.
  function automatic logic [19:0] div100(input logic [19:0] x);
    logic [39:0] prod;
    prod = 40'(x) * 40'd671089;
    return 20'(prod >> 26);
  endfunction

endpackage
`default_nettype wire

[rtl/schedule_fade_pwm_engine_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Daily schedule engine that turns stored schedule points into PWM values.
// Input beats are commands: clear, append point, set level, set channel
// limits and evaluate. A beat is taken when start is high and busy is low.
// Results leave on out_data, each valid for one cycle while out_valid is
// high; the receiver cannot stall the block, so no back pressure exists.
// Clear, append and set limits answer in the cycle right after the beat and
// leave busy low. Set level reads and rewrites a level row, holding busy
// while it writes the row in state S_LVLWR, where its answer beat is
// registered; a slot beyond the table answers at once with a no-slot status.
// Evaluate scans the point memory one entry per cycle, reads the two level
// rows, runs a serial division for the fade percentage, then passes each
// reported channel through states S_CHA to S_CHD, S_CHD registering its
// result beat; busy is low again when the last beat appears.
// The scan through the point memory and the serial divider set how long an evaluate lasts.
// An evaluate on an empty table answers at once with a single beat.
// Reset empties the table and clears the channel limits; no clearing pass
// is needed because a point's levels are zeroed when it is appended.
module schedule_fade_pwm_engine_unit #(
  parameter int MAX_POINTS = 16,
  parameter int CHANNELS = 4,
  parameter int PWM_BITS = 12
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire sfpe_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  output sfpe_pkg::out_beat_t      out_data
);
  import sfpe_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ROW_W = CHANNELS * LEVEL_W;
  localparam int REPORT = (CHANNELS < 4) ? CHANNELS : 4;
  localparam logic [16:0] PWM_MASK = (17'd1 << PWM_BITS) - 17'd1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LVLWR = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_RDP   = 10'b0000001000,
    S_RDN   = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_CHA   = 10'b0001000000,
    S_CHB   = 10'b0010000000,
    S_CHC   = 10'b0100000000,
    S_CHD   = 10'b1000000000
  } state_t;

  logic [TIME_W:0]  pt_mem [MAX_POINTS];
  logic [ROW_W-1:0] lvl_mem [MAX_POINTS];
  logic [TIME_W:0]  pt_rdata_r;
  logic [ROW_W-1:0] lvl_rdata_r;
  logic [11:0]      lim_lo_r [CHANNELS];
  logic [11:0]      lim_hi_r [CHANNELS];

  state_t           state_r, state_nxt;
  logic [PCW-1:0]   count_r, count_nxt;
  logic [PCW-1:0]   scan_idx_r, scan_idx_nxt;
  logic [AW-1:0]    scan_pos_r;
  logic             scan_vld_r, scan_vld_nxt;
  logic [10:0]      now_r;
  logic signed [11:0] bp_r;
  logic [11:0]      bn_r;
  logic [AW-1:0]    ip_r, inx_r;
  logic             fade_n_r;
  logic [AW-1:0]    slot_r;
  logic [1:0]       ch_in_r;
  logic [6:0]       level_r;
  logic [ROW_W-1:0] lp_row_r, ln_row_r;
  logic [6:0]       pct_r;
  logic [1:0]       ch_r, ch_nxt;
  logic [6:0]       lp_c_r, ln_c_r;
  logic             go_fade_r, neg_r;
  logic [13:0]      d_r;
  logic [6:0]       lvl_r;
  logic [18:0]      v_r;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_r, out_nxt;

  logic             accept;
  logic             pt_we, lvl_we, pt_re, lvl_re, lim_we;
  logic [AW-1:0]    pt_waddr, pt_raddr, lvl_waddr, lvl_raddr;
  logic [TIME_W:0]  pt_wdata;
  logic [ROW_W-1:0] lvl_wdata, row_mod;
  logic [4:0]       hour_sat;
  logic [5:0]       min_sat;
  logic [10:0]      now_sat;
  logic [10:0]      scan_t;
  logic signed [11:0] tp;
  logic [11:0]      tn;
  logic             take_p, take_n;
  logic signed [12:0] total, elapsed;
  logic             div_go, div_done;
  logic [17:0]      div_num, div_q;
  logic [6:0]       lp_c, ln_c, q_lvl;
  logic [7:0]       mag;
  logic [CW-1:0]    in_ch_idx, ch_idx;
  logic             in_ch_ok;
  int               v_full;
  logic [19:0]      pwm_full;

  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign hour_sat = (in_data.at_hour > 5'd23) ? 5'd23 : in_data.at_hour;
  assign min_sat = (in_data.at_minute > 6'd59) ? 6'd59 : in_data.at_minute;
  assign now_sat = (in_data.now_minute > LAST_MINUTE) ? LAST_MINUTE : in_data.now_minute;
  assign in_ch_idx = CW'(in_data.channel);
  assign in_ch_ok = 32'(in_data.channel) < CHANNELS;
  assign ch_idx = CW'(ch_r);

  assign pt_we = accept && (in_data.cmd == CMD_APPEND) && (32'(count_r) < MAX_POINTS);
  assign pt_waddr = AW'(count_r);
  assign pt_wdata = {in_data.fade_on, 11'(hour_sat) * 11'd60 + 11'(min_sat)};
  assign pt_re = (state_r == S_SCAN) && (32'(scan_idx_r) < 32'(count_r));
  assign pt_raddr = AW'(scan_idx_r);

  always_comb begin
    row_mod = lvl_rdata_r;
    row_mod[32'(ch_in_r) * LEVEL_W +: LEVEL_W] = (level_r > 7'd100) ? 7'd100 : level_r;
  end

  always_comb begin
    lvl_we = pt_we;
    lvl_waddr = pt_waddr;
    lvl_wdata = '0;
    if (state_r == S_LVLWR) begin
      lvl_we = (32'(ch_in_r) < CHANNELS);
      lvl_waddr = slot_r;
      lvl_wdata = row_mod;
    end
  end

  always_comb begin
    lvl_re = 1'b0;
    lvl_raddr = ip_r;
    if (accept && (in_data.cmd == CMD_LEVEL)) begin
      lvl_re = 1'b1;
      lvl_raddr = AW'(in_data.slot);
    end else if (state_r == S_RDP) begin
      lvl_re = 1'b1;
    end else if (state_r == S_RDN) begin
      lvl_re = 1'b1;
      lvl_raddr = inx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (pt_re) begin
      pt_rdata_r <= pt_mem[pt_raddr];
    end
    if (lvl_we) begin
      lvl_mem[lvl_waddr] <= lvl_wdata;
    end
    if (lvl_re) begin
      lvl_rdata_r <= lvl_mem[lvl_raddr];
    end
  end

  assign scan_t = pt_rdata_r[TIME_W-1:0];
  assign tp = (scan_t < now_r) ? $signed({1'b0, scan_t}) :
              $signed({1'b0, scan_t}) - $signed(DAY_MINUTES);
  assign tn = (scan_t >= now_r) ? {1'b0, scan_t} : {1'b0, scan_t} + DAY_MINUTES;
  assign take_p = scan_vld_r && ((scan_pos_r == '0) || (tp > bp_r));
  assign take_n = scan_vld_r && ((scan_pos_r == '0) || (tn < bn_r));

  assign total = $signed({1'b0, bn_r}) - 13'(bp_r);
  assign elapsed = $signed({2'b00, now_r}) - 13'(bp_r);
  assign div_go = (state_r == S_RDN);
  assign div_num = 18'(elapsed[10:0]) * 18'd100;

  sfpe_divider #(
    .NW(18),
    .DW(12)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (div_go),
    .dividend(div_num),
    .divisor (total[11:0]),
    .done    (div_done),
    .quotient(div_q)
  );

  assign lp_c = lp_row_r[32'(ch_r) * LEVEL_W +: LEVEL_W];
  assign ln_c = ln_row_r[32'(ch_r) * LEVEL_W +: LEVEL_W];
  assign mag = (ln_c < lp_c) ? 8'(lp_c) - 8'(ln_c) : 8'(ln_c) - 8'(lp_c);
  assign q_lvl = 7'(div100(20'(d_r)));
  assign v_full = int'(lim_lo_r[ch_idx]) * 100 +
                  (int'(lim_hi_r[ch_idx]) - int'(lim_lo_r[ch_idx])) * int'(lvl_r);
  assign pwm_full = div100(20'(v_r)) & 20'(PWM_MASK);
  assign lim_we = accept && (in_data.cmd == CMD_LIMITS) && in_ch_ok;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    scan_idx_nxt = scan_idx_r;
    scan_vld_nxt = 1'b0;
    ch_nxt = ch_r;
    out_valid_nxt = 1'b0;
    out_nxt = '0;
    out_nxt.last = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            CMD_CLEAR: begin
              count_nxt = '0;
              out_valid_nxt = 1'b1;
            end
            CMD_APPEND: begin
              out_valid_nxt = 1'b1;
              if (pt_we) begin
                count_nxt = count_r + 1'b1;
              end else begin
                out_nxt.status = ST_FULL;
              end
            end
            CMD_LEVEL: begin
              if ((32'(in_data.slot) < 32'(count_r)) && (32'(in_data.slot) < MAX_POINTS)) begin
                state_nxt = S_LVLWR;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt.status = ST_NO_SLOT;
              end
            end
            CMD_LIMITS: begin
              out_valid_nxt = 1'b1;
            end
            CMD_EVAL: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
                scan_idx_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LVLWR: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (pt_re) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          scan_vld_nxt = 1'b1;
        end else if (!scan_vld_r) begin
          state_nxt = S_RDP;
        end
      end
      S_RDP: begin
        state_nxt = S_RDN;
      end
      S_RDN: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_CHA;
          ch_nxt = '0;
        end
      end
      S_CHA: begin
        state_nxt = S_CHB;
      end
      S_CHB: begin
        state_nxt = S_CHC;
      end
      S_CHC: begin
        state_nxt = S_CHD;
      end
      S_CHD: begin
        out_valid_nxt = 1'b1;
        out_nxt.out_channel = ch_r;
        out_nxt.pwm = pwm_full[11:0];
        out_nxt.last = (32'(ch_r) == REPORT - 1);
        if (32'(ch_r) == REPORT - 1) begin
          state_nxt = S_IDLE;
        end else begin
          ch_nxt = ch_r + 1'b1;
          state_nxt = S_CHA;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      scan_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        lim_lo_r[i] <= '0;
        lim_hi_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      scan_vld_r <= scan_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (lim_we) begin
        lim_lo_r[in_ch_idx] <= in_data.limit_low;
        lim_hi_r[in_ch_idx] <= in_data.limit_high;
      end
    end
    out_r <= out_nxt;
    scan_idx_r <= scan_idx_nxt;
    scan_pos_r <= AW'(scan_idx_r);
    ch_r <= ch_nxt;
    if (accept) begin
      now_r <= now_sat;
      slot_r <= AW'(in_data.slot);
      ch_in_r <= in_data.channel;
      level_r <= in_data.level;
    end
    if (take_p) begin
      bp_r <= tp;
      ip_r <= scan_pos_r;
    end
    if (take_n) begin
      bn_r <= tn;
      inx_r <= scan_pos_r;
      fade_n_r <= pt_rdata_r[TIME_W];
    end
    if (state_r == S_RDN) begin
      lp_row_r <= lvl_rdata_r;
    end
    if ((state_r == S_DIV) && div_done) begin
      ln_row_r <= lvl_rdata_r;
      pct_r <= div_q[6:0];
    end
    if (state_r == S_CHA) begin
      lp_c_r <= lp_c;
      ln_c_r <= ln_c;
      go_fade_r <= fade_n_r && (lp_c != ln_c);
      neg_r <= (ln_c < lp_c);
      d_r <= 14'(mag[6:0]) * 14'(pct_r);
    end
    if (state_r == S_CHB) begin
      if (go_fade_r) begin
        lvl_r <= neg_r ? lp_c_r - q_lvl : lp_c_r + q_lvl;
      end else begin
        lvl_r <= ln_c_r;
      end
    end
    if (state_r == S_CHC) begin
      v_r <= (v_full < 0) ? '0 : 19'(v_full);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(accept) || $past(state_r == S_CHD) || $past(state_r == S_LVLWR)))
    else $error("result beat without a cause");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.cmd == CMD_APPEND) && (32'(count_r) >= MAX_POINTS))
    |=> $stable(count_r))
    else $error("append into a full table changed the count");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the division step");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> !busy)
    else $error("final result beat while still busy");

endmodule
`default_nettype wire

[rtl/sfpe_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
module sfpe_divider #(
  parameter int NW = 18,
  parameter int DW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient
);
  localparam int CW = $clog2(NW + 1);

  logic [DW:0]   rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [DW+1:0] shifted;
  logic [DW+1:0] diff;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dsr_nxt = dsr_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    done_nxt = 1'b0;
    shifted = {rem_r, quo_r[NW-1]};
    diff = shifted - {2'b00, dsr_r};
    if (go) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dsr_nxt = divisor;
      cnt_nxt = CW'(NW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[DW+1]) begin
        rem_nxt = diff[DW:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire
